[rtl/tslnf_pkg.sv]
// Shared types and constants of the text stream line number filter.
package tslnf_pkg;

   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBER_NONBLANK  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_ENDS        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBER_ALL       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SQUEEZE_BLANK    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_TABS        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_NONPRINTING = 3'd5;

   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_DOLLAR  = 8'd36;
   localparam logic [7:0] CHAR_DASH    = 8'd45;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_I       = 8'd73;
   localparam logic [7:0] CHAR_M       = 8'd77;
   localparam logic [7:0] CHAR_CARET   = 8'd94;
   localparam logic [7:0] CHAR_DEL     = 8'd127;
   localparam logic [7:0] CHAR_HIGH    = 8'd160;
   localparam logic [7:0] CASE_OFFSET  = 8'd64;

   typedef struct packed {
      logic number_nonblank;
      logic show_ends;
      logic number_all;
      logic squeeze_blank;
      logic show_tabs;
      logic show_nonprinting;
   } mode_type;

   typedef struct packed {
      logic       prefix;
      logic       number;
      logic       dollar;
      logic       meta;
      logic       caret;
      logic [7:0] final_byte;
   } desc_type;

endpackage

[rtl/tslnf_if.sv]
// Request and response channel interfaces of the text stream line number filter.
interface tslnf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       file_start;

   modport source (output valid, output in_byte, output file_start, input ready);
   modport sink (input valid, input in_byte, input file_start, output ready);
endinterface

interface tslnf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

[rtl/text_stream_line_number_filter_top.sv]
// Top level of the text stream line number filter.
//
//   channel   direction  payload                      transaction
//   req_chan  in         in_byte[7:0], file_start     valid && ready
//   rsp_chan  out        out_byte[7:0], last_of_run   valid && ready
//   csr_*     in         csr_index[2:0], csr_wdata    csr_we
//
// One input byte is accepted per cycle when it yields a single output byte and the
// response is not stalled; a byte that yields more holds the input until the
// response register, one byte per transaction, sends its last. A squeezed blank
// line is accepted and yields nothing. Reset is synchronous and clears modes,
// line state and the response register. A stalled response holds its byte and the input.
module text_stream_line_number_filter_top #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [tslnf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic                              csr_wdata,
   tslnf_req_if.sink                         req_chan,
   tslnf_rsp_if.source                       rsp_chan
);

   logic                       load, load_ok;
   tslnf_pkg::desc_type        desc;
   logic [4*NUMBER_DIGITS-1:0] count_bcd;

   tslnf_decode #(
      .NUMBER_DIGITS(NUMBER_DIGITS)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .load_ok   (load_ok),
      .load      (load),
      .desc      (desc),
      .count_bcd (count_bcd)
   );

   tslnf_emit #(
      .NUMBER_DIGITS(NUMBER_DIGITS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .desc      (desc),
      .count_bcd (count_bcd),
      .load_ok   (load_ok),
      .rsp_chan  (rsp_chan)
   );

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_of_run) |=> rsp_chan.valid)
      else $error("response run broke before its last byte");

   a_take_on_last: assert property (@(posedge clock) disable iff (reset)
      (req_chan.ready && rsp_chan.valid) |-> (rsp_chan.last_of_run && rsp_chan.ready))
      else $error("input taken while a response run is still pending");

   a_run_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(req_chan.valid && req_chan.ready))
      else $error("response started without an accepted transaction");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> load_ok)
      else $error("descriptor loaded over a pending run");

endmodule

[rtl/tslnf_decode.sv]
// Input decode: mode registers, line state and per-byte output descriptor.
module tslnf_decode #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [tslnf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic                                 csr_wdata,
   tslnf_req_if.sink                            req_chan,
   input  logic                                 load_ok,
   output logic                                 load,
   output tslnf_pkg::desc_type                  desc,
   output logic [4*NUMBER_DIGITS-1:0]           count_bcd
);

   localparam int BCD_W = 4 * NUMBER_DIGITS;

   function automatic logic [BCD_W-1:0] bcd_increment(input logic [BCD_W-1:0] value);
      logic [BCD_W-1:0] next;
      logic             carry;
      logic [3:0]       digit;
      next  = '0;
      carry = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         digit = value[4*i +: 4];
         if (carry && digit == 4'd9) begin
            next[4*i +: 4] = 4'd0;
            carry          = 1'b1;
         end else begin
            next[4*i +: 4] = digit + {3'b000, carry};
            carry          = 1'b0;
         end
      end
      return carry ? value : next;
   endfunction

   tslnf_pkg::mode_type mode_ff, mode_in;
   logic                prev_nl_ff;
   logic [1:0]          blank_ff, blank_in, blank_base;
   logic [BCD_W-1:0]    count_ff, count_in, count_base;

   logic       accept, was_nl, is_nl, is_tab, squeeze_hit, drop, number_hit, pad;
   logic [7:0] c, c_conv;
   logic       meta, ctrl_caret, tab_caret;

   assign req_chan.ready = load_ok;
   assign accept         = req_chan.valid && load_ok;

   assign c          = req_chan.in_byte;
   assign is_nl      = (c == tslnf_pkg::CHAR_NEWLINE);
   assign is_tab     = (c == tslnf_pkg::CHAR_TAB);
   assign was_nl     = req_chan.file_start || prev_nl_ff;
   assign blank_base = req_chan.file_start ? 2'd0 : blank_ff;
   assign count_base = req_chan.file_start ? '0 : count_ff;

   assign squeeze_hit = mode_ff.squeeze_blank && is_nl && was_nl;
   assign blank_in    = !squeeze_hit ? 2'd0 : (blank_base == 2'd2) ? 2'd2 : blank_base + 2'd1;
   assign drop        = squeeze_hit && (blank_in == 2'd2);

   assign number_hit = was_nl && ((mode_ff.number_nonblank && !is_nl) ||
                                  (mode_ff.number_all && !mode_ff.number_nonblank));
   assign pad        = mode_ff.show_ends && mode_ff.number_nonblank && is_nl && was_nl;
   assign count_in   = (number_hit && !drop) ? bcd_increment(count_base) : count_base;

   assign meta       = mode_ff.show_nonprinting && c[7] && (c < tslnf_pkg::CHAR_HIGH);
   assign ctrl_caret = mode_ff.show_nonprinting &&
                       ((c == tslnf_pkg::CHAR_DEL) || (c < 8'd32 && !is_nl && !is_tab));
   assign tab_caret  = mode_ff.show_tabs && is_tab;

   always_comb begin
      c_conv = c;
      if (meta || (mode_ff.show_nonprinting && c == tslnf_pkg::CHAR_DEL)) begin
         c_conv = c - tslnf_pkg::CASE_OFFSET;
      end else if (ctrl_caret) begin
         c_conv = c + tslnf_pkg::CASE_OFFSET;
      end else if (tab_caret) begin
         c_conv = tslnf_pkg::CHAR_I;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      if (csr_we) begin
         unique case (csr_index)
            tslnf_pkg::CSR_NUMBER_NONBLANK:  mode_in.number_nonblank  = csr_wdata;
            tslnf_pkg::CSR_SHOW_ENDS:        mode_in.show_ends        = csr_wdata;
            tslnf_pkg::CSR_NUMBER_ALL:       mode_in.number_all       = csr_wdata;
            tslnf_pkg::CSR_SQUEEZE_BLANK:    mode_in.squeeze_blank    = csr_wdata;
            tslnf_pkg::CSR_SHOW_TABS:        mode_in.show_tabs        = csr_wdata;
            tslnf_pkg::CSR_SHOW_NONPRINTING: mode_in.show_nonprinting = csr_wdata;
            default:                         mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= '0;
         prev_nl_ff <= 1'b1;
         blank_ff   <= 2'd0;
         count_ff   <= '0;
      end else begin
         mode_ff <= mode_in;
         if (accept) begin
            prev_nl_ff <= is_nl;
            blank_ff   <= blank_in;
            count_ff   <= count_in;
         end
      end
   end

   assign load      = accept && !drop;
   assign count_bcd = count_in;

   assign desc.prefix     = number_hit || pad;
   assign desc.number     = number_hit;
   assign desc.dollar     = mode_ff.show_ends && is_nl;
   assign desc.meta       = meta;
   assign desc.caret      = meta || ctrl_caret || tab_caret;
   assign desc.final_byte = c_conv;

endmodule

[rtl/tslnf_emit.sv]
// Output sequencer: holds one descriptor and emits its bytes one per transaction.
module tslnf_emit #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  tslnf_pkg::desc_type        desc,
   input  logic [4*NUMBER_DIGITS-1:0] count_bcd,
   output logic                       load_ok,
   tslnf_rsp_if.source                rsp_chan
);

   localparam int BCD_W  = 4 * NUMBER_DIGITS;
   localparam int SLOT_W = $clog2(NUMBER_DIGITS + 6);

   localparam logic [SLOT_W-1:0] SLOT_TAB    = SLOT_W'(NUMBER_DIGITS);
   localparam logic [SLOT_W-1:0] SLOT_DOLLAR = SLOT_W'(NUMBER_DIGITS + 1);
   localparam logic [SLOT_W-1:0] SLOT_M      = SLOT_W'(NUMBER_DIGITS + 2);
   localparam logic [SLOT_W-1:0] SLOT_DASH   = SLOT_W'(NUMBER_DIGITS + 3);
   localparam logic [SLOT_W-1:0] SLOT_CARET  = SLOT_W'(NUMBER_DIGITS + 4);
   localparam logic [SLOT_W-1:0] SLOT_FINAL  = SLOT_W'(NUMBER_DIGITS + 5);
   localparam logic [SLOT_W-1:0] SLOT_MSD    = SLOT_W'(NUMBER_DIGITS - 1);

   logic                desc_valid_ff, desc_valid_in;
   tslnf_pkg::desc_type desc_ff, desc_in;
   logic [BCD_W-1:0]    bcd_ff, bcd_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in, slot_next, slot_start;

   logic              advance, last;
   logic [SLOT_W-1:0] digit_pos;
   logic [3:0]        digit;
   logic              upper_zero, suppress;
   logic [7:0]        out_byte;

   always_comb begin
      if (desc.prefix) begin
         slot_start = '0;
      end else if (desc.dollar) begin
         slot_start = SLOT_DOLLAR;
      end else if (desc.meta) begin
         slot_start = SLOT_M;
      end else if (desc.caret) begin
         slot_start = SLOT_CARET;
      end else begin
         slot_start = SLOT_FINAL;
      end
   end

   always_comb begin
      priority if (slot_ff < SLOT_TAB) begin
         slot_next = slot_ff + 1'b1;
      end else if (slot_ff == SLOT_TAB && desc_ff.dollar) begin
         slot_next = SLOT_DOLLAR;
      end else if ((slot_ff == SLOT_TAB || slot_ff == SLOT_DOLLAR) && desc_ff.meta) begin
         slot_next = SLOT_M;
      end else if (slot_ff == SLOT_M) begin
         slot_next = SLOT_DASH;
      end else if ((slot_ff == SLOT_TAB || slot_ff == SLOT_DOLLAR || slot_ff == SLOT_DASH)
                   && desc_ff.caret) begin
         slot_next = SLOT_CARET;
      end else begin
         slot_next = SLOT_FINAL;
      end
   end

   assign digit_pos  = SLOT_MSD - slot_ff;
   assign digit      = 4'(bcd_ff >> {digit_pos, 2'b00});
   assign upper_zero = ((bcd_ff >> {digit_pos, 2'b00}) >> 4) == '0;
   assign suppress   = (digit == 4'd0) && upper_zero && (digit_pos != '0);

   always_comb begin
      priority if (slot_ff < SLOT_TAB) begin
         out_byte = (desc_ff.number && !suppress) ?
                    tslnf_pkg::CHAR_ZERO + {4'b0000, digit} : tslnf_pkg::CHAR_SPACE;
      end else if (slot_ff == SLOT_TAB) begin
         out_byte = tslnf_pkg::CHAR_TAB;
      end else if (slot_ff == SLOT_DOLLAR) begin
         out_byte = tslnf_pkg::CHAR_DOLLAR;
      end else if (slot_ff == SLOT_M) begin
         out_byte = tslnf_pkg::CHAR_M;
      end else if (slot_ff == SLOT_DASH) begin
         out_byte = tslnf_pkg::CHAR_DASH;
      end else if (slot_ff == SLOT_CARET) begin
         out_byte = tslnf_pkg::CHAR_CARET;
      end else begin
         out_byte = desc_ff.final_byte;
      end
   end

   assign last    = (slot_ff == SLOT_FINAL);
   assign advance = desc_valid_ff && rsp_chan.ready;
   assign load_ok = !desc_valid_ff || (advance && last);

   assign rsp_chan.valid       = desc_valid_ff;
   assign rsp_chan.out_byte    = out_byte;
   assign rsp_chan.last_of_run = last;

   always_comb begin
      desc_valid_in = desc_valid_ff;
      desc_in       = desc_ff;
      bcd_in        = bcd_ff;
      slot_in       = slot_ff;
      if (load) begin
         desc_valid_in = 1'b1;
         desc_in       = desc;
         bcd_in        = count_bcd;
         slot_in       = slot_start;
      end else if (advance) begin
         if (last) begin
            desc_valid_in = 1'b0;
         end else begin
            slot_in = slot_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_valid_ff <= 1'b0;
         slot_ff       <= SLOT_FINAL;
      end else begin
         desc_valid_ff <= desc_valid_in;
         slot_ff       <= slot_in;
      end
      desc_ff <= desc_in;
      bcd_ff  <= bcd_in;
   end

endmodule

[tb/tslnf_format_checker.sv]
`timescale 1ns / 100ps
// Checker that predicts the formatted byte stream of the line number filter and compares it.
module tslnf_format_checker #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [tslnf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic                              csr_wdata,
   tslnf_req_if                              req_chan,
   tslnf_rsp_if                              rsp_chan,
   output int                                mismatch_count,
   output int                                bytes_pending
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } formatted_byte_type;

   tslnf_pkg::mode_type        modes;
   logic [7:0]                 previous_byte;
   logic [1:0]                 blank_run;
   logic [4*NUMBER_DIGITS-1:0] line_count_bcd;
   formatted_byte_type         expected_bytes[$];

   // saturate at all nines
   function automatic void count_line();
      logic [4*NUMBER_DIGITS-1:0] next_count;
      logic                       carry;
      logic [4:0]                 digit;
      next_count = '0;
      carry = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         digit = {1'b0, line_count_bcd[4*i +: 4]} + carry;
         if (digit > 5'd9) begin
            digit = '0;
            carry = 1'b1;
         end else begin
            carry = 1'b0;
         end
         next_count[4*i +: 4] = digit[3:0];
      end
      if (!carry) begin
         line_count_bcd = next_count;
      end
   endfunction

   function automatic void format_byte(input logic [7:0] in_byte, input logic file_start);
      logic [7:0] c;
      logic       was_newline;
      logic       leading;
      logic [3:0] digit;
      logic [7:0] run[$];
      c = in_byte;
      if (file_start) begin
         line_count_bcd = '0;
         previous_byte = tslnf_pkg::CHAR_NEWLINE;
         blank_run = '0;
      end
      was_newline = (previous_byte == tslnf_pkg::CHAR_NEWLINE);

      if (modes.squeeze_blank && c == tslnf_pkg::CHAR_NEWLINE && was_newline) begin
         if (blank_run < 2'd2) begin
            blank_run = blank_run + 2'd1;
         end
         if (blank_run > 2'd1) begin
            return;
         end
      end else begin
         blank_run = '0;
      end

      if (was_newline && ((modes.number_nonblank && c != tslnf_pkg::CHAR_NEWLINE) ||
                          (modes.number_all && !modes.number_nonblank))) begin
         count_line();
         leading = 1'b1;
         for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            digit = line_count_bcd[4*i +: 4];
            if (digit == 4'd0 && leading && i > 0) begin
               run.push_back(tslnf_pkg::CHAR_SPACE);
            end else begin
               leading = 1'b0;
               run.push_back(tslnf_pkg::CHAR_ZERO + digit);
            end
         end
         run.push_back(tslnf_pkg::CHAR_TAB);
      end

      if (modes.show_ends) begin
         if (modes.number_nonblank && c == tslnf_pkg::CHAR_NEWLINE && was_newline) begin
            repeat (NUMBER_DIGITS) run.push_back(tslnf_pkg::CHAR_SPACE);
            run.push_back(tslnf_pkg::CHAR_TAB);
         end
         if (c == tslnf_pkg::CHAR_NEWLINE) begin
            run.push_back(tslnf_pkg::CHAR_DOLLAR);
         end
      end

      if (modes.show_nonprinting) begin
         if (c[7] && c < tslnf_pkg::CHAR_HIGH) begin
            run.push_back(tslnf_pkg::CHAR_M);
            run.push_back(tslnf_pkg::CHAR_DASH);
            run.push_back(tslnf_pkg::CHAR_CARET);
         end
         if (c == tslnf_pkg::CHAR_DEL ||
             (c < tslnf_pkg::CHAR_SPACE && c != tslnf_pkg::CHAR_NEWLINE &&
              c != tslnf_pkg::CHAR_TAB)) begin
            run.push_back(tslnf_pkg::CHAR_CARET);
         end
         if ((c < tslnf_pkg::CHAR_SPACE ||
              (c >= tslnf_pkg::CHAR_DEL && c < tslnf_pkg::CHAR_HIGH)) &&
             c != tslnf_pkg::CHAR_NEWLINE && c != tslnf_pkg::CHAR_TAB) begin
            c = (c >= tslnf_pkg::CHAR_DEL) ? c - tslnf_pkg::CASE_OFFSET :
                                             c + tslnf_pkg::CASE_OFFSET;
         end
      end

      if (modes.show_tabs && c == tslnf_pkg::CHAR_TAB) begin
         run.push_back(tslnf_pkg::CHAR_CARET);
         c = tslnf_pkg::CHAR_I;
      end

      run.push_back(c);
      previous_byte = c;
      foreach (run[i]) begin
         expected_bytes.push_back(formatted_byte_type'{run[i], i == run.size() - 1});
      end
   endfunction

   always @(posedge clock) begin
      formatted_byte_type expected;
      if (reset) begin
         modes = '0;
         previous_byte = tslnf_pkg::CHAR_NEWLINE;
         blank_run = '0;
         line_count_bcd = '0;
         expected_bytes.delete();
         mismatch_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tslnf_pkg::CSR_NUMBER_NONBLANK:  modes.number_nonblank = csr_wdata;
               tslnf_pkg::CSR_SHOW_ENDS:        modes.show_ends = csr_wdata;
               tslnf_pkg::CSR_NUMBER_ALL:       modes.number_all = csr_wdata;
               tslnf_pkg::CSR_SQUEEZE_BLANK:    modes.squeeze_blank = csr_wdata;
               tslnf_pkg::CSR_SHOW_TABS:        modes.show_tabs = csr_wdata;
               tslnf_pkg::CSR_SHOW_NONPRINTING: modes.show_nonprinting = csr_wdata;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            format_byte(req_chan.in_byte, req_chan.file_start);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_bytes.size() == 0) begin
               mismatch_count++;
               $display({"%0t: unexpected transaction, expected none, ",
                         "actual out_byte %h last_of_run %b"},
                        $time, rsp_chan.out_byte, rsp_chan.last_of_run);
            end else begin
               expected = expected_bytes.pop_front();
               if (rsp_chan.out_byte !== expected.out_byte) begin
                  mismatch_count++;
                  $display("%0t: out_byte expected %h actual %h",
                           $time, expected.out_byte, rsp_chan.out_byte);
               end
               if (rsp_chan.last_of_run !== expected.last_of_run) begin
                  mismatch_count++;
                  $display("%0t: last_of_run expected %b actual %b",
                           $time, expected.last_of_run, rsp_chan.last_of_run);
               end
            end
         end
      end
      bytes_pending = expected_bytes.size();
   end

endmodule

[tb/text_stream_line_number_filter_top_tb.sv]
`timescale 1ns / 100ps
// Testbench top that feeds text bytes and mode writes to the line number filter and gives the verdict.
module text_stream_line_number_filter_top_tb;

   localparam int HOLD_CYCLES     = 120;
   localparam int DRAIN_CYCLES    = 16;
   localparam int ITEMS_PER_PHASE = 45;
   localparam int RANDOM_PHASES   = 6;
   localparam logic [tslnf_pkg::CSR_INDEX_W-1:0] CSR_UNUSED =
      tslnf_pkg::CSR_SHOW_NONPRINTING + 1'b1;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              csr_we;
   logic [tslnf_pkg::CSR_INDEX_W-1:0] csr_index;
   logic                              csr_wdata;
   int                                mismatch_count;
   int                                bytes_pending;
   logic                              idling_on = 1'b1;
   int                                hold_requests = 0;
   int                                hold_served = 0;
   int                                hold_left = 0;

   tslnf_req_if req_chan();
   tslnf_rsp_if rsp_chan();

   text_stream_line_number_filter_top u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   tslnf_format_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .mismatch_count (mismatch_count),
      .bytes_pending  (bytes_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left--;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !(idling_on && $urandom_range(99) < 31);
      end
   end

   task automatic write_register(input logic [tslnf_pkg::CSR_INDEX_W-1:0] index,
                                 input logic value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_modes(input tslnf_pkg::mode_type modes);
      write_register(CSR_UNUSED, 1'($urandom_range(1)));
      write_register(tslnf_pkg::CSR_NUMBER_NONBLANK, modes.number_nonblank);
      write_register(tslnf_pkg::CSR_SHOW_ENDS, modes.show_ends);
      write_register(tslnf_pkg::CSR_NUMBER_ALL, modes.number_all);
      write_register(tslnf_pkg::CSR_SQUEEZE_BLANK, modes.squeeze_blank);
      write_register(tslnf_pkg::CSR_SHOW_TABS, modes.show_tabs);
      write_register(tslnf_pkg::CSR_SHOW_NONPRINTING, modes.show_nonprinting);
      csr_we <= 1'b0;
   endtask

   task automatic send_byte(input logic [7:0] value, input logic file_start);
      if (idling_on && $urandom_range(99) < 31) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.in_byte <= value;
      req_chan.file_start <= file_start;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // hold until every predicted byte is out, then let a dropped line finish
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (bytes_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] text_byte();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) return 8'($urandom_range("z", "a"));
      if (pick < 65) return tslnf_pkg::CHAR_NEWLINE;
      if (pick < 70) return tslnf_pkg::CHAR_TAB;
      if (pick < 75) return tslnf_pkg::CHAR_SPACE;
      if (pick < 82) return 8'($urandom_range(31, 0));
      if (pick < 86) return 8'($urandom_range(159, 127));
      if (pick < 92) return 8'($urandom_range(255, 160));
      return 8'($urandom_range(255, 0));
   endfunction

   task automatic send_text(input int count);
      int sent;
      int run_length;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 8) begin
            run_length = $urandom_range(4, 2);
            repeat (run_length) send_byte(tslnf_pkg::CHAR_NEWLINE, 1'b0);
            sent += run_length;
         end else begin
            send_byte(text_byte(), $urandom_range(99) < 3);
            sent++;
         end
      end
   endtask

   initial begin
      tslnf_pkg::mode_type modes;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= 1'b0;
      req_chan.valid <= 1'b0;
      req_chan.in_byte <= '0;
      req_chan.file_start <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      modes = '1;
      apply_modes(modes);
      send_byte("a", 1'b1);
      send_byte(tslnf_pkg::CHAR_NEWLINE, 1'b0);
      send_byte(tslnf_pkg::CHAR_NEWLINE, 1'b0);
      send_byte(tslnf_pkg::CHAR_NEWLINE, 1'b0);
      send_byte(tslnf_pkg::CHAR_NEWLINE, 1'b0);
      send_byte(tslnf_pkg::CHAR_TAB, 1'b0);
      send_byte(8'd0, 1'b0);
      send_byte(8'd31, 1'b0);
      send_byte(tslnf_pkg::CHAR_DEL, 1'b0);
      send_byte(8'd128, 1'b0);
      send_byte(8'd159, 1'b0);
      send_byte(tslnf_pkg::CHAR_HIGH, 1'b0);
      send_byte(8'd255, 1'b0);
      send_byte(tslnf_pkg::CHAR_SPACE, 1'b0);
      send_byte(tslnf_pkg::CHAR_NEWLINE, 1'b0);
      send_byte(tslnf_pkg::CHAR_NEWLINE, 1'b1);
      send_byte("b", 1'b0);
      send_byte(tslnf_pkg::CHAR_NEWLINE, 1'b0);
      drain();

      modes = '0;
      modes.number_all = 1'b1;
      modes.squeeze_blank = 1'b1;
      apply_modes(modes);
      send_byte(tslnf_pkg::CHAR_NEWLINE, 1'b1);
      send_byte(tslnf_pkg::CHAR_NEWLINE, 1'b0);
      send_byte(tslnf_pkg::CHAR_NEWLINE, 1'b0);
      send_byte("x", 1'b0);
      send_byte(tslnf_pkg::CHAR_NEWLINE, 1'b0);
      send_byte(tslnf_pkg::CHAR_TAB, 1'b0);
      drain();

      modes = '0;
      apply_modes(modes);
      send_text(ITEMS_PER_PHASE);
      drain();

      // stall the output long enough to back up the input
      modes = '0;
      modes.number_all = 1'b1;
      apply_modes(modes);
      hold_requests++;
      send_text(ITEMS_PER_PHASE);
      drain();

      idling_on = 1'b0;
      modes = '1;
      apply_modes(modes);
      send_text(ITEMS_PER_PHASE);
      drain();
      idling_on = 1'b1;

      repeat (RANDOM_PHASES) begin
         modes = tslnf_pkg::mode_type'($urandom_range(63));
         apply_modes(modes);
         send_text(ITEMS_PER_PHASE);
         drain();
      end

      if (mismatch_count == 0 && bytes_pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

[sim.f]
rtl/tslnf_pkg.sv
rtl/tslnf_if.sv
rtl/tslnf_decode.sv
rtl/tslnf_emit.sv
rtl/text_stream_line_number_filter_top.sv
tb/tslnf_format_checker.sv
tb/text_stream_line_number_filter_top_tb.sv
